### rtl/b36_pkg.sv
package b36_pkg;

  // Input number width and the chunked long division used to divide by 36
  localparam int ID_W    = 37;
  localparam int CHUNK_W = 16;
  localparam int NCHUNK  = (ID_W + CHUNK_W - 1) / CHUNK_W;
  localparam int WORK_W  = NCHUNK * CHUNK_W;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;
  localparam int CHUNK_CNT_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  // One division step: x = {remainder, chunk}, x < 36 * 2**CHUNK_W
  localparam int STEP_W  = DIGIT_W + CHUNK_W;
  localparam int PROD_W  = 2 * STEP_W;
  // floor(x / 36) = (x * RECIP) >> RECIP_SH, exact for every x below 36 * 2**16
  localparam int RECIP_SH = 27;
  localparam logic [STEP_W-1:0] RECIP = STEP_W'((64'd1 << RECIP_SH) / 36 + 64'd1);

  localparam logic [DIGIT_W-1:0] RADIX    = DIGIT_W'(36);
  localparam logic [CHAR_W-1:0]  ASCII_0  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_A  = CHAR_W'(65);
  localparam logic [DIGIT_W-1:0] DEC_TOP  = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_9  = CHAR_W'(57);
  localparam logic [CHAR_W-1:0]  ASCII_Z  = CHAR_W'(90);

  // Request held in the queue between front and back
  typedef struct packed {
    logic [ID_W-1:0] value;
    logic            is_zero;
  } b36_entry_t;

  // 36 to the power n, evaluated at elaboration
  function automatic logic [63:0] pow36(input int n);
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < n; i++) begin
      acc = acc * 64'd36;
    end
    return acc;
  endfunction

  // Map one base-36 digit to its upper-case ASCII code
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_TOP) begin
      c = ASCII_0 + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - DEC_TOP);
    end
    return c;
  endfunction

endpackage

### rtl/binary_to_base36_ascii.sv
// Channel   Ports                                       Direction  Handshake
// input     in_id_value[36:0]                           in         in_valid / in_ready
// result    out_digit_char[6:0], out_last_char,         out        out_valid / out_ready
//           out_empty_result
//
// A number of n base-36 digits is divided digit by digit, one 16-bit chunk per
// cycle through the divide-by-36 step, after the request is taken from the queue;
// its characters then leave through the single result register. Zero gives one
// empty result without division. Reset (rst_n, synchronous, active low) empties
// the two-entry request queue and the result register. A stalled result stalls
// only the back end; the front keeps taking requests until the queue is full.
module binary_to_base36_ascii import b36_pkg::*; #(
  parameter int MAX_DIGITS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ID_W-1:0]   in_id_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_digit_char,
  output logic              out_last_char,
  output logic              out_empty_result
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;
  b36_entry_t push_entry;
  b36_entry_t pop_entry;

  b36_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_id_value (in_id_value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (push_entry)
  );

  b36_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  b36_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_entry          (pop_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digit_char   (out_digit_char),
    .out_last_char    (out_last_char),
    .out_empty_result (out_empty_result)
  );

  // An empty result is a lone, final result with no character
  a_empty_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_result |-> out_last_char && (out_digit_char == '0))
    else $error("empty result not flagged as last");

  // Every digit result carries a base-36 character
  a_char_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_empty_result |->
      ((out_digit_char >= ASCII_0) && (out_digit_char <= ASCII_9)) ||
      ((out_digit_char >= ASCII_A) && (out_digit_char <= ASCII_Z)))
    else $error("result character outside base-36 alphabet");

  // Leave reset with an empty queue, ready for a request
  a_ready_after_reset : assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not ready after reset");

  // Never pop an empty queue
  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("request queue underflow");

endmodule

### rtl/b36_front.sv
module b36_front import b36_pkg::*; #(
  parameter int MAX_DIGITS = 7
) (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [ID_W-1:0] in_id_value,
  input  logic            q_full,
  output logic            q_push,
  output b36_entry_t      q_entry
);

  localparam logic [63:0] LIMIT   = pow36(MAX_DIGITS);
  localparam logic [63:0] SAT_VAL = LIMIT - 64'd1;

  logic [ID_W-1:0] value_sat;

  // Clamp numbers that need more digits than the block can produce
  always_comb begin
    if ({{(64-ID_W){1'b0}}, in_id_value} >= LIMIT) begin
      value_sat = SAT_VAL[ID_W-1:0];
    end else begin
      value_sat = in_id_value;
    end
  end

  // Classify and hand the request to the queue
  assign in_ready        = !q_full;
  assign q_push          = in_valid && !q_full;
  assign q_entry.value   = value_sat;
  assign q_entry.is_zero = (in_id_value == '0);

endmodule

### rtl/b36_fifo.sv
module b36_fifo import b36_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  b36_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output b36_entry_t pop_entry
);

  localparam int DEPTH = 2;
  localparam int PTR_W = 1;
  localparam int CNT_W = 2;

  b36_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_entry = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold request payloads
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### rtl/b36_back.sv
module b36_back import b36_pkg::*; #(
  parameter int MAX_DIGITS = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  b36_entry_t        q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_digit_char,
  output logic              out_last_char,
  output logic              out_empty_result
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [WORK_W-1:0]      work_r, work_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [CHUNK_CNT_W-1:0] chunk_r, chunk_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_empty_r, out_empty_nxt;
  logic [DIGIT_W-1:0]     store_r [MAX_DIGITS];

  logic [STEP_W-1:0]  step_x;
  logic [PROD_W-1:0]  step_prod;
  logic [CHUNK_W-1:0] step_q;
  logic [STEP_W-1:0]  step_qx36;
  logic [STEP_W-1:0]  step_r_full;
  logic [DIGIT_W-1:0] step_r;
  logic [WORK_W-1:0]  work_shift;
  logic               last_chunk;
  logic               slot_free;
  logic               store_we;

  // One long-division step: next 16-bit chunk under the running remainder
  always_comb begin
    step_x      = {rem_r, work_r[WORK_W-1 -: CHUNK_W]};
    step_prod   = {{STEP_W{1'b0}}, step_x} * {{STEP_W{1'b0}}, RECIP};
    step_q      = step_prod[RECIP_SH +: CHUNK_W];
    step_qx36   = ({{DIGIT_W{1'b0}}, step_q} << 5) + ({{DIGIT_W{1'b0}}, step_q} << 2);
    step_r_full = step_x - step_qx36;
    step_r      = step_r_full[DIGIT_W-1:0];
    work_shift  = {work_r[WORK_W-CHUNK_W-1:0], step_q};
  end

  assign last_chunk = (chunk_r == CHUNK_CNT_W'(NCHUNK - 1));
  assign slot_free  = !out_valid_r || out_ready;
  assign q_pop      = (state_r == ST_IDLE) && q_not_empty && (!q_entry.is_zero || slot_free);
  assign store_we   = (state_r == ST_DIV) && last_chunk;

  // Sequencer: take a request, divide digit by digit, then emit most significant first
  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    chunk_nxt     = chunk_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (q_entry.is_zero) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_empty_nxt = 1'b1;
          end else begin
            work_nxt  = WORK_W'(q_entry.value);
            rem_nxt   = '0;
            chunk_nxt = '0;
            idx_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        work_nxt  = work_shift;
        rem_nxt   = step_r;
        chunk_nxt = chunk_r + CHUNK_CNT_W'(1);
        if (last_chunk) begin
          rem_nxt   = '0;
          chunk_nxt = '0;
          if (work_shift == '0 || idx_r == IDX_W'(MAX_DIGITS - 1)) begin
            state_nxt = ST_EMIT;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_ascii(store_r[idx_r]);
          out_last_nxt  = (idx_r == '0);
          out_empty_nxt = 1'b0;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      chunk_r     <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chunk_r     <= chunk_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Hold datapath and result payloads
  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    rem_r       <= rem_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  // Digit store, written least significant first
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[idx_r] <= step_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_char   = out_char_r;
  assign out_last_char    = out_last_r;
  assign out_empty_result = out_empty_r;

endmodule

### verif/binary_to_base36_ascii_test.sv
module binary_to_base36_ascii_test import b36_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIGITS = 7;
  localparam logic [63:0] DIGIT_BASE = 64'd36;
  localparam logic [63:0] ID_LIMIT = DIGIT_BASE ** NUM_DIGITS;
  localparam logic [63:0] ID_SPAN = 64'd1 << ID_W;
  localparam logic [CHAR_W-1:0] CODE_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CODE_LETTER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CODE_NONE = 7'h00;
  localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;
  localparam int IDLE_MAX = 13;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 60;

  // One expected character of a converted number
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_last;
    logic              is_empty;
  } char_exp_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [ID_W-1:0]   in_id_value;
  logic              out_valid;
  logic              out_ready;
  logic [CHAR_W-1:0] out_digit_char;
  logic              out_last_char;
  logic              out_empty_result;

  char_exp_t pending_chars[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        idle_limit = IDLE_MAX;
  int        rx_hold_cycles = 0;

  binary_to_base36_ascii #(.MAX_DIGITS(NUM_DIGITS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_id_value      (in_id_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digit_char   (out_digit_char),
    .out_last_char    (out_last_char),
    .out_empty_result (out_empty_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("binary_to_base36_ascii verification failed");
      $finish;
    end
  end

  function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
    if (d < DECIMAL_DIGITS) begin
      return CODE_ZERO + CHAR_W'(d);
    end
    return CODE_LETTER_A + CHAR_W'(d - DECIMAL_DIGITS);
  endfunction

  // Convert one number and queue its characters, most significant first
  task automatic queue_base36_chars(input logic [ID_W-1:0] id);
    logic [63:0]        rest;
    logic [DIGIT_W-1:0] digits[NUM_DIGITS];
    int                 n;
    char_exp_t          c;
    rest = 64'(id);
    n = 0;
    if (rest >= ID_LIMIT) begin
      rest = ID_LIMIT - 64'd1;
    end
    if (rest == 64'd0) begin
      c.code = CODE_NONE;
      c.is_last = 1'b1;
      c.is_empty = 1'b1;
      pending_chars.push_back(c);
    end else begin
      while (rest != 64'd0 && n < NUM_DIGITS) begin
        digits[n] = DIGIT_W'(rest % DIGIT_BASE);
        rest = rest / DIGIT_BASE;
        n++;
      end
      for (int k = 0; k < n; k++) begin
        c.code = char_of_digit(digits[n - 1 - k]);
        c.is_last = (k == n - 1);
        c.is_empty = 1'b0;
        pending_chars.push_back(c);
      end
    end
  endtask

  // Offer one request after a random gap and hold it until taken
  task automatic send_id(input logic [ID_W-1:0] id);
    int gap;
    gap = $urandom_range(0, idle_limit);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_id_value <= id;
    do @(posedge clk); while (!in_ready);
    queue_base36_chars(id);
  endtask

  // Drop valid and wait for every outstanding character
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  function automatic logic [ID_W-1:0] rand_id_digits(input int n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] r;
    lo = (n == 1) ? 64'd1 : DIGIT_BASE ** (n - 1);
    hi = DIGIT_BASE ** n - 64'd1;
    r = {$urandom, $urandom};
    return ID_W'(lo + r % (hi - lo + 64'd1));
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      7, 8: return ID_W'(r);
      9: return ID_W'(ID_LIMIT + r % (ID_SPAN - ID_LIMIT));
      default: return rand_id_digits($urandom_range(1, NUM_DIGITS));
    endcase
  endfunction

  // Accept characters with random stalls and compare with the oldest expected
  initial begin
    int        stall;
    char_exp_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      stall = $urandom_range(0, idle_limit);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_chars.size() == 0) begin
        $error("unexpected character: digit_char %0d last_char %0b empty_result %0b",
               out_digit_char, out_last_char, out_empty_result);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_digit_char !== want.code) begin
          $error("digit_char: expected %0d, actual %0d", want.code, out_digit_char);
          fail_count++;
        end
        if (out_last_char !== want.is_last) begin
          $error("last_char: expected %0b, actual %0b", want.is_last, out_last_char);
          fail_count++;
        end
        if (out_empty_result !== want.is_empty) begin
          $error("empty_result: expected %0b, actual %0b", want.is_empty, out_empty_result);
          fail_count++;
        end
      end
    end
  end

  // Extremes, digit-count boundaries, zero and saturation
  task automatic test_directed();
    send_id('0);
    send_id(ID_W'(1));
    send_id(ID_W'(9));
    send_id(ID_W'(10));
    send_id(ID_W'(35));
    for (int n = 1; n < NUM_DIGITS; n++) begin
      send_id(ID_W'(DIGIT_BASE ** n - 64'd1));
      send_id(ID_W'(DIGIT_BASE ** n));
    end
    send_id(ID_W'(ID_LIMIT - 64'd1));
    send_id(ID_W'(ID_LIMIT));
    send_id('1);
    send_id(ID_W'(64'd1 << (ID_W - 1)));
    send_id('0);
    send_id('0);
    send_id(ID_W'(64'h0_5555_5555));
    wait_drain();
  endtask

  // Random numbers, with a stretch where neither side idles
  task automatic test_random();
    for (int i = 0; i < 110; i++) begin
      idle_limit = (i >= 40 && i < 70) ? 0 : IDLE_MAX;
      send_id(rand_id());
    end
    idle_limit = IDLE_MAX;
    wait_drain();
  endtask

  // Hold the receiver off while requests keep coming so the input stalls
  task automatic test_backpressure();
    idle_limit = 0;
    rx_hold_cycles = 400;
    for (int i = 0; i < 12; i++) begin
      send_id(rand_id_digits($urandom_range(1, NUM_DIGITS)));
    end
    idle_limit = IDLE_MAX;
    wait_drain();
  endtask

  // Pause the sender until all output has gone, then carry on
  task automatic test_drain_pause();
    for (int i = 0; i < 16; i++) begin
      send_id(rand_id());
      if (i % 4 == 3) begin
        wait_drain();
      end
    end
    wait_drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_id_value <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();

    // Let any stray character show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("binary_to_base36_ascii verification clean");
    end else begin
      $display("binary_to_base36_ascii verification failed");
    end
    $finish;
  end

endmodule
